@@ src/skht_pkg.sv @@
// Shared constants, types and codes for the string key hash table.
package skht_pkg;

    // Table geometry
    localparam int TABLE_SLOTS = 256;
    localparam int KEY_BYTES   = 32;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int KEY_CNT_W   = $clog2(KEY_BYTES + 2);
    localparam int KEY_IDX_W   = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    // Hash multiplier and product width
    localparam int HASH_MUL    = 131;
    localparam int HASH_PROD_W = SLOT_W + 9;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 2;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 24;
    localparam int OUT_PAD  = OUT_W - VALUE_W - STATUS_W;

    // Item kinds carried on s_tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_MISS     = 2'd1,
        ST_FULL     = 2'd2,
        ST_TOO_LONG = 2'd3
    } status_t;

    typedef logic [KEY_BYTES-1:0][BYTE_W-1:0] key_buf_t;

    // Commands from the controller to the key accumulator
    typedef struct packed {
        logic take;
        logic restart;
    } key_cmd_t;

    // One stored slot: key bytes, key length and value
    typedef struct packed {
        key_buf_t               key;
        logic [KEY_CNT_W-1:0]   len;
        logic [VALUE_W-1:0]     value;
    } slot_row_t;

endpackage

@@ src/skht_key_accum.sv @@
// Key byte buffer, byte count and running hash of the key being received.
module skht_key_accum (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  skht_pkg::key_cmd_t            key_cmd,
    input  logic [skht_pkg::BYTE_W-1:0]   key_byte,
    output skht_pkg::key_buf_t            key_buf,
    output logic [skht_pkg::KEY_CNT_W-1:0] key_count,
    output logic [skht_pkg::SLOT_W-1:0]   key_hash
);
    import skht_pkg::*;

    key_buf_t               buf_reg, buf_next;
    logic [KEY_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SLOT_W-1:0]      hash_reg, hash_next;
    logic [HASH_PROD_W-1:0] hash_prod;

    // Only the low SLOT_W bits of the hash reach the home slot
    assign hash_prod = HASH_PROD_W'(hash_reg) * HASH_PROD_W'(HASH_MUL)
                     + HASH_PROD_W'(key_byte);

    // Append one byte, or restart the key
    always_comb begin
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        hash_next = hash_reg;
        if (key_cmd.restart) begin
            buf_next  = '0;
            cnt_next  = '0;
            hash_next = '0;
        end else if (key_cmd.take) begin
            hash_next = hash_prod[SLOT_W-1:0];
            if (cnt_reg < KEY_CNT_W'(KEY_BYTES)) begin
                buf_next[cnt_reg[KEY_IDX_W-1:0]] = key_byte;
            end
            if (cnt_reg <= KEY_CNT_W'(KEY_BYTES)) begin
                cnt_next = cnt_reg + KEY_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg  <= '0;
            cnt_reg  <= '0;
            hash_reg <= '0;
        end else begin
            buf_reg  <= buf_next;
            cnt_reg  <= cnt_next;
            hash_reg <= hash_next;
        end
    end

    assign key_buf   = buf_reg;
    assign key_count = cnt_reg;
    assign key_hash  = hash_reg;

endmodule

@@ src/skht_slot_mem.sv @@
// Slot memory: key, length and value per slot, one write and one registered read port.
module skht_slot_mem (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [skht_pkg::SLOT_W-1:0] wr_addr,
    input  skht_pkg::slot_row_t         wr_row,
    input  logic                        rd_en,
    input  logic [skht_pkg::SLOT_W-1:0] rd_addr,
    output skht_pkg::slot_row_t         rd_row
);
    import skht_pkg::*;

    slot_row_t mem [TABLE_SLOTS];
    slot_row_t rd_row_reg;

    // Write the inserted slot
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
    end

    // Read one slot, data valid the next cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

@@ src/string_key_hash_table.sv @@
// Key byte item: accepted while idle. Last byte: a start state, then an insert scans
// 1 slot per cycle and a lookup reads each slot, then compares its key (LREAD, LCMP);
// the probe length is set by table occupancy, up to TABLE_SLOTS slots. S_DONE hands
// the result to the output register once it is free. Clear has no clearing pass.
// Reset (aresetn low, synchronous): table empty, key restarted, default_value 9.
module string_key_hash_table (
    input  logic                         aclk,
    input  logic                         aresetn,
    // tdata: key_byte [7:0], entry_value [23:8]
    input  logic [skht_pkg::IN_W-1:0]    s_tdata,
    // tuser: kind [1:0]
    input  logic [skht_pkg::KIND_W-1:0]  s_tuser,
    input  logic                         s_tlast,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // tdata: result_value [15:0], status [17:16], zero [23:18]
    output logic [skht_pkg::OUT_W-1:0]   m_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [skht_pkg::VALUE_W-1:0] cfg_data
);
    import skht_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_INS   = 6'b000100,
        S_LREAD = 6'b001000,
        S_LCMP  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    localparam logic [SLOT_W-1:0] TRIES_LAST = SLOT_W'(TABLE_SLOTS - 1);

    state_t                 state_reg, state_next;
    logic [TABLE_SLOTS-1:0] used_reg, used_next;
    logic [SLOT_W-1:0]      pos_reg, pos_next;
    logic [SLOT_W-1:0]      tries_reg, tries_next;
    logic                   lookup_reg, lookup_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [VALUE_W-1:0]     res_value_reg, res_value_next;
    status_t                res_status_reg, res_status_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]       m_data_reg, m_data_next;
    logic [VALUE_W-1:0]     default_reg;

    key_cmd_t               key_cmd;
    key_buf_t               key_buf;
    logic [KEY_CNT_W-1:0]   key_count;
    logic [SLOT_W-1:0]      key_hash;

    logic                   mem_wr_en;
    logic                   mem_rd_en;
    slot_row_t              wr_row;
    slot_row_t              rd_row;

    logic                   in_acc;
    kind_t                  in_kind;
    logic                   key_hit;

    assign in_acc   = s_tvalid && s_tready;
    assign in_kind  = kind_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE);

    assign key_hit  = (rd_row.len == key_count) && (rd_row.key == key_buf);

    assign wr_row.key   = key_buf;
    assign wr_row.len   = key_count;
    assign wr_row.value = value_reg;

    skht_key_accum u_key (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .key_cmd   (key_cmd),
        .key_byte  (s_tdata[BYTE_W-1:0]),
        .key_buf   (key_buf),
        .key_count (key_count),
        .key_hash  (key_hash)
    );

    skht_slot_mem u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (pos_reg),
        .wr_row  (wr_row),
        .rd_en   (mem_rd_en),
        .rd_addr (pos_reg),
        .rd_row  (rd_row)
    );

    // Sequence accumulation, probing and result hand-off
    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        pos_next        = pos_reg;
        tries_next      = tries_reg;
        lookup_next     = lookup_reg;
        value_next      = value_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        key_cmd         = '0;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;

        // Drop the shown item once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    case (in_kind)
                        KIND_CLEAR: begin
                            used_next       = '0;
                            key_cmd.restart = 1'b1;
                            res_value_next  = '0;
                            res_status_next = ST_DONE;
                            state_next      = S_DONE;
                        end
                        KIND_INSERT, KIND_LOOKUP: begin
                            key_cmd.take = 1'b1;
                            if (s_tlast) begin
                                lookup_next = (in_kind == KIND_LOOKUP);
                                value_next  = s_tdata[BYTE_W +: VALUE_W];
                                state_next  = S_START;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_START: begin
                tries_next = '0;
                pos_next   = key_hash;
                if (key_count > KEY_CNT_W'(KEY_BYTES)) begin
                    key_cmd.restart = 1'b1;
                    res_value_next  = '0;
                    res_status_next = ST_TOO_LONG;
                    state_next      = S_DONE;
                end else if (lookup_reg) begin
                    state_next = S_LREAD;
                end else begin
                    state_next = S_INS;
                end
            end
            S_INS: begin
                res_value_next = '0;
                if (!used_reg[pos_reg]) begin
                    mem_wr_en          = 1'b1;
                    used_next[pos_reg] = 1'b1;
                    key_cmd.restart    = 1'b1;
                    res_status_next    = ST_DONE;
                    state_next         = S_DONE;
                end else if (tries_reg == TRIES_LAST) begin
                    key_cmd.restart = 1'b1;
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end else begin
                    pos_next   = pos_reg + SLOT_W'(1);
                    tries_next = tries_reg + SLOT_W'(1);
                end
            end
            S_LREAD: begin
                if (!used_reg[pos_reg]) begin
                    key_cmd.restart = 1'b1;
                    res_value_next  = default_reg;
                    res_status_next = ST_MISS;
                    state_next      = S_DONE;
                end else begin
                    mem_rd_en  = 1'b1;
                    state_next = S_LCMP;
                end
            end
            S_LCMP: begin
                if (key_hit) begin
                    key_cmd.restart = 1'b1;
                    res_value_next  = rd_row.value;
                    res_status_next = ST_DONE;
                    state_next      = S_DONE;
                end else if (tries_reg == TRIES_LAST) begin
                    key_cmd.restart = 1'b1;
                    res_value_next  = default_reg;
                    res_status_next = ST_MISS;
                    state_next      = S_DONE;
                end else begin
                    pos_next   = pos_reg + SLOT_W'(1);
                    tries_next = tries_reg + SLOT_W'(1);
                    state_next = S_LREAD;
                end
            end
            S_DONE: begin
                // Load the output register when it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{OUT_PAD{1'b0}}, res_status_reg, res_value_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
            default_reg <= VALUE_W'(9);
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                default_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        tries_reg      <= tries_next;
        lookup_reg     <= lookup_next;
        value_reg      <= value_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

endmodule

@@ src/skht_checker.sv @@
// Port-level checker for the string key hash table, bound to the top level.
module skht_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic [skht_pkg::KIND_W-1:0]  s_tuser,
    input logic                         s_tlast,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [skht_pkg::OUT_W-1:0]   m_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready
);
    import skht_pkg::*;

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // A clear item blocks input while its result is handed off
    a_clear_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_CLEAR) |=> !s_tready)
        else $error("input accepted right after clear");

    // A completed key starts an operation that blocks input
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast
        && ((s_tuser == KIND_INSERT) || (s_tuser == KIND_LOOKUP)) |=> !s_tready)
        else $error("input accepted during operation start");

    // Full and too-long results carry a zero value
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tdata[17:16] == ST_FULL) || (m_tdata[17:16] == ST_TOO_LONG))
        |-> (m_tdata[15:0] == '0))
        else $error("nonzero value on a rejected item");

endmodule

bind string_key_hash_table skht_checker u_skht_checker (.*);
